/* design/csvft_pkg.sv */
package csvft_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] K_BYTE     = 2'd0;
    localparam logic [1:0] K_FIELD    = 2'd1;
    localparam logic [1:0] K_FIELDROW = 2'd2;
    localparam logic [1:0] K_ROW      = 2'd3;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ST_BETWEEN    = 3'd0,
        ST_FIELDSTART = 3'd1,
        ST_UNQUOTED   = 3'd2,
        ST_QUOTED     = 3'd3,
        ST_QUOTESEEN  = 3'd4
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } token_t;

endpackage

/* design/csv_field_tokenizer.sv */
// CSV field tokenizer.
// Input channel (s_valid/s_ready): one byte of CSV text per item in s_in_byte,
// or an end-of-text mark in s_end_of_input (the byte is then ignored).
// Result channel (m_valid/m_ready): tokens, each a content byte, a field end,
// a field-and-row end or a row end, with m_last set on the final token that
// one input item causes. An item causes zero, one or two tokens.
// Each accepted item is parsed in the cycle it is accepted by the state
// register and its next-state logic, and its tokens are pushed into a
// four-entry result queue.
// Throughput: one input item per cycle while the receiver keeps up; s_ready
// is high while the queue holds two tokens or fewer, so that the two tokens
// of a stray byte after a closing quote always fit.
// Reset (synchronous, aresetn low): the parser returns to between rows and
// the queue is emptied. When the receiver stalls, queued tokens hold and
// s_ready drops as soon as the queue may not fit another item's tokens.
module csv_field_tokenizer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  logic                  s_end_of_input,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_out_kind,
    output logic [7:0]            m_out_byte,
    output logic                  m_last
);
    import csvft_pkg::*;

    parse_state_t              state_reg, state_next;
    token_t                    queue_reg [QDEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]         count_reg, count_next;

    logic                      accept;
    logic                      pop;
    logic                      line_end;
    logic [1:0]                n_tok;
    token_t                    tok0, tok1;
    logic [QPTR_W-1:0]         wr_ptr_plus1;

    assign accept   = s_valid && s_ready;
    assign pop      = m_valid && m_ready;
    assign line_end = (s_in_byte == CH_CR) || (s_in_byte == CH_LF);

    always_comb begin
        state_next = state_reg;
        if (s_end_of_input) begin
            state_next = ST_BETWEEN;
        end else begin
            case (state_reg)
                ST_FIELDSTART, ST_BETWEEN: begin
                    if (line_end)                   state_next = ST_BETWEEN;
                    else if (s_in_byte == CH_QUOTE) state_next = ST_QUOTED;
                    else if (s_in_byte == CH_COMMA) state_next = ST_FIELDSTART;
                    else                            state_next = ST_UNQUOTED;
                end
                ST_UNQUOTED: begin
                    if (s_in_byte == CH_COMMA) state_next = ST_FIELDSTART;
                    else if (line_end)         state_next = ST_BETWEEN;
                end
                ST_QUOTED: begin
                    if (s_in_byte == CH_QUOTE) state_next = ST_QUOTESEEN;
                end
                ST_QUOTESEEN: begin
                    if (s_in_byte == CH_QUOTE)      state_next = ST_QUOTED;
                    else if (s_in_byte == CH_COMMA) state_next = ST_FIELDSTART;
                    else if (line_end)              state_next = ST_BETWEEN;
                    else                            state_next = ST_UNQUOTED;
                end
                default: begin
                    if (line_end)                   state_next = ST_BETWEEN;
                    else if (s_in_byte == CH_QUOTE) state_next = ST_QUOTED;
                    else if (s_in_byte == CH_COMMA) state_next = ST_FIELDSTART;
                    else                            state_next = ST_UNQUOTED;
                end
            endcase
        end
    end

    always_comb begin
        n_tok = 2'd0;
        tok0  = '{kind: K_BYTE, data: 8'd0, last: 1'b1};
        tok1  = '{kind: K_BYTE, data: 8'd0, last: 1'b1};
        if (s_end_of_input) begin
            if (state_reg == ST_FIELDSTART) begin
                n_tok     = 2'd1;
                tok0.kind = K_ROW;
            end else if (state_reg == ST_UNQUOTED || state_reg == ST_QUOTED
                         || state_reg == ST_QUOTESEEN) begin
                n_tok     = 2'd1;
                tok0.kind = K_FIELDROW;
            end
        end else begin
            case (state_reg)
                ST_UNQUOTED: begin
                    n_tok = 2'd1;
                    if (s_in_byte == CH_COMMA) begin
                        tok0.kind = K_FIELD;
                    end else if (line_end) begin
                        tok0.kind = K_FIELDROW;
                    end else begin
                        tok0.data = s_in_byte;
                    end
                end
                ST_QUOTED: begin
                    if (s_in_byte != CH_QUOTE) begin
                        n_tok     = 2'd1;
                        tok0.data = s_in_byte;
                    end
                end
                ST_QUOTESEEN: begin
                    n_tok = 2'd1;
                    if (s_in_byte == CH_QUOTE) begin
                        tok0.data = CH_QUOTE;
                    end else if (s_in_byte == CH_COMMA) begin
                        tok0.kind = K_FIELD;
                    end else if (line_end) begin
                        tok0.kind = K_FIELDROW;
                    end else begin
                        n_tok     = 2'd2;
                        tok0.kind = K_FIELD;
                        tok0.last = 1'b0;
                        tok1.data = s_in_byte;
                    end
                end
                default: begin
                    if (line_end) begin
                        if (state_reg == ST_FIELDSTART) begin
                            n_tok     = 2'd1;
                            tok0.kind = K_ROW;
                        end
                    end else if (s_in_byte == CH_COMMA) begin
                        n_tok     = 2'd1;
                        tok0.kind = K_FIELD;
                    end else if (s_in_byte != CH_QUOTE) begin
                        n_tok     = 2'd1;
                        tok0.data = s_in_byte;
                    end
                end
            endcase
        end
    end

    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(n_tok);
            count_next  = count_next + QCNT_W'(n_tok);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            count_next  = count_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_BETWEEN;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && n_tok != 2'd0) begin
            queue_reg[wr_ptr_reg] <= tok0;
        end
        if (accept && n_tok == 2'd2) begin
            queue_reg[wr_ptr_plus1] <= tok1;
        end
    end

    assign s_ready    = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign m_valid    = (count_reg != '0);
    assign m_out_kind = queue_reg[rd_ptr_reg].kind;
    assign m_out_byte = queue_reg[rd_ptr_reg].data;
    assign m_last     = queue_reg[rd_ptr_reg].last;

endmodule

/* test/csv_field_tokenizer_tb.sv */
`timescale 1ns / 100ps

module csv_field_tokenizer_tb;
    import csvft_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
    } text_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_end_of_input = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_out_kind;
    logic [7:0] m_out_byte;
    logic       m_last;

    text_item_t   text_q[$];
    token_t       token_q[$];
    parse_state_t parse_st = ST_BETWEEN;
    token_t       want_tok;
    text_item_t   next_item;
    int           fail_cnt = 0;
    int           idle_cycles = 0;
    int           gap_left = 0;
    int           burst_left = 0;
    int           rdy_mode = 0;
    int           rdy_left = 0;

    csv_field_tokenizer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic token_t make_token(logic [1:0] kind, logic [7:0] data);
        token_t t;
        t.kind = kind;
        t.data = (kind == K_BYTE) ? data : 8'h00;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void tokenize_item(logic [7:0] b, logic eoi);
        token_t toks[$];
        logic   line_end;
        line_end = (b == CH_CR) || (b == CH_LF);
        if (eoi) begin
            if (parse_st == ST_FIELDSTART) begin
                toks.push_back(make_token(K_ROW, 8'h00));
            end else if (parse_st != ST_BETWEEN) begin
                toks.push_back(make_token(K_FIELDROW, 8'h00));
            end
            parse_st = ST_BETWEEN;
        end else begin
            case (parse_st)
                ST_UNQUOTED: begin
                    if (b == CH_COMMA) begin
                        toks.push_back(make_token(K_FIELD, 8'h00));
                        parse_st = ST_FIELDSTART;
                    end else if (line_end) begin
                        toks.push_back(make_token(K_FIELDROW, 8'h00));
                        parse_st = ST_BETWEEN;
                    end else begin
                        toks.push_back(make_token(K_BYTE, b));
                    end
                end
                ST_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        parse_st = ST_QUOTESEEN;
                    end else begin
                        toks.push_back(make_token(K_BYTE, b));
                    end
                end
                ST_QUOTESEEN: begin
                    if (b == CH_QUOTE) begin
                        toks.push_back(make_token(K_BYTE, CH_QUOTE));
                        parse_st = ST_QUOTED;
                    end else if (b == CH_COMMA) begin
                        toks.push_back(make_token(K_FIELD, 8'h00));
                        parse_st = ST_FIELDSTART;
                    end else if (line_end) begin
                        toks.push_back(make_token(K_FIELDROW, 8'h00));
                        parse_st = ST_BETWEEN;
                    end else begin
                        toks.push_back(make_token(K_FIELD, 8'h00));
                        toks.push_back(make_token(K_BYTE, b));
                        parse_st = ST_UNQUOTED;
                    end
                end
                default: begin
                    if (line_end) begin
                        if (parse_st == ST_FIELDSTART) begin
                            toks.push_back(make_token(K_ROW, 8'h00));
                        end
                        parse_st = ST_BETWEEN;
                    end else if (b == CH_QUOTE) begin
                        parse_st = ST_QUOTED;
                    end else if (b == CH_COMMA) begin
                        toks.push_back(make_token(K_FIELD, 8'h00));
                        parse_st = ST_FIELDSTART;
                    end else begin
                        toks.push_back(make_token(K_BYTE, b));
                        parse_st = ST_UNQUOTED;
                    end
                end
            endcase
        end
        if (toks.size() != 0) begin
            toks[toks.size() - 1].last = 1'b1;
        end
        foreach (toks[i]) begin
            token_q.push_back(toks[i]);
        end
    endfunction

    function automatic logic [7:0] rand_any();
        case ($urandom_range(0, 9))
            0: return CH_QUOTE;
            1: return CH_COMMA;
            2: return CH_LF;
            3: return CH_CR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR);
        return b;
    endfunction

    task automatic add_byte(logic [7:0] b);
        text_item_t it;
        it.data = b;
        it.eoi = 1'b0;
        text_q.push_back(it);
    endtask

    task automatic add_eoi();
        text_item_t it;
        it.data = 8'($urandom_range(0, 255));
        it.eoi = 1'b1;
        text_q.push_back(it);
    endtask

    task automatic add_field();
        int         len;
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: begin
            end
            1, 2, 3: begin
                len = $urandom_range(1, 6);
                add_byte(rand_plain());
                for (int i = 1; i < len; i++) begin
                    add_byte(($urandom_range(0, 9) == 0) ? CH_QUOTE : rand_plain());
                end
            end
            default: begin
                len = $urandom_range(0, 6);
                add_byte(CH_QUOTE);
                for (int i = 0; i < len; i++) begin
                    c = rand_any();
                    add_byte(c);
                    if (c == CH_QUOTE) begin
                        add_byte(CH_QUOTE);
                    end
                end
                add_byte(CH_QUOTE);
                if ($urandom_range(0, 7) == 0) begin
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++) begin
                        add_byte(rand_plain());
                    end
                end
            end
        endcase
    endtask

    task automatic add_row();
        int nf;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f != 0) begin
                add_byte(CH_COMMA);
            end
            add_field();
        end
        case ($urandom_range(0, 7))
            0, 1, 2: add_byte(CH_LF);
            3, 4: begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            5: begin
                add_byte(CH_COMMA);
                add_byte(CH_LF);
            end
            6: add_eoi();
            default: begin
                add_byte(CH_LF);
                add_byte(CH_CR);
                add_byte(CH_LF);
                add_byte(CH_LF);
            end
        endcase
    endtask

    task automatic add_noise();
        int len;
        if ($urandom_range(0, 3) == 0) begin
            add_eoi();
        end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                add_byte(rand_any());
            end
        end
    endtask

    initial begin
        int target;
        add_eoi();
        add_byte(CH_COMMA);
        add_byte(CH_LF);
        add_byte(CH_LF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_CR);
        add_byte(CH_QUOTE);
        add_byte(CH_COMMA);
        add_byte(CH_LF);
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_byte(8'h78);
        add_byte(CH_COMMA);
        add_byte(CH_CR);
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_byte(CH_COMMA);
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_eoi();
        add_byte(8'h62);
        add_eoi();
        add_byte(CH_COMMA);
        add_eoi();
        add_byte(CH_QUOTE);
        add_eoi();

        target = text_q.size() + RANDOM_ITEMS;
        while (text_q.size() < target) begin
            if ($urandom_range(0, 9) < 8) begin
                add_row();
            end else begin
                add_noise();
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_valid) @(posedge aclk);
        while (token_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (token_q.size() != 0) begin
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            parse_st = ST_BETWEEN;
        end else begin
            if (s_valid && s_ready) begin
                tokenize_item(s_in_byte, s_end_of_input);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    next_item = text_q.pop_front();
                    s_valid <= 1'b1;
                    s_in_byte <= next_item.data;
                    s_end_of_input <= next_item.eoi;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = (rdy_mode == 2) ? $urandom_range(1, 6) : $urandom_range(10, 60);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= 1'b0;
            default: m_ready <= ~m_ready;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (token_q.size() == 0) begin
                if (fail_cnt < 10) begin
                    $display("unexpected token: kind %0d byte %02h last %0b",
                             m_out_kind, m_out_byte, m_last);
                end
                fail_cnt++;
            end else begin
                want_tok = token_q.pop_front();
                if (m_out_kind !== want_tok.kind || m_out_byte !== want_tok.data ||
                    m_last !== want_tok.last) begin
                    if (fail_cnt < 10) begin
                        $display("token mismatch: got kind %0d byte %02h last %0b, %s",
                                 m_out_kind, m_out_byte, m_last,
                                 $sformatf("expected kind %0d byte %02h last %0b",
                                           want_tok.kind, want_tok.data, want_tok.last));
                    end
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
